>>> design/exif_pkg.sv
// ----------------------------------------------------------------------------
// exif_pkg: shared types and constants of the EXIF orientation parser
// Phase codes, marker constants and the front-to-back item struct.
// ----------------------------------------------------------------------------
package exif_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] TAG_ORIENT = 16'h0112;
    localparam logic [7:0] MARK_APP1 = 8'hE1;
    localparam logic [7:0] MARK_SOS = 8'hDA;
    localparam logic [7:0] MARK_EOI = 8'hD9;
    localparam logic [7:0] MARK_SOI = 8'hD8;
    localparam logic [7:0] MARK_TEM = 8'h01;
    localparam logic [7:0] PNG_FIRST = 8'h89;
    localparam logic [31:0] CHUNK_EXIF = 32'h65584966;
    localparam logic [31:0] CHUNK_IDAT = 32'h49444154;
    localparam logic [31:0] CHUNK_IEND = 32'h49454E44;

    localparam logic [1:0] CONT_NONE = 2'd0;
    localparam logic [1:0] CONT_JPEG = 2'd1;
    localparam logic [1:0] CONT_PNG = 2'd2;

    typedef enum logic [4:0]
    {
        PH_FIRST = 5'd0, PH_SECOND = 5'd1, PH_PNGSIG = 5'd2, PH_JSCAN = 5'd3,
        PH_JMARK = 5'd4, PH_JLEN = 5'd5, PH_JSKIP = 5'd6, PH_JEXIF = 5'd7,
        PH_PLEN = 5'd8, PH_PTYPE = 5'd9, PH_PSKIP = 5'd10, PH_PCRC = 5'd11,
        PH_TBO = 5'd12, PH_TMAGIC = 5'd13, PH_TOFF = 5'd14, PH_TSEEK = 5'd15,
        PH_TCOUNT = 5'd16, PH_TENTRY = 5'd17, PH_TTAIL = 5'd18
    } phase_t;

    typedef struct packed
    {
        logic [3:0] orientation;
        logic [1:0] container;
        logic exif_present;
        logic swaps_axes;
    } result_t;

    function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        begin
            unique case (idx)
                3'd0: v = 8'h89;
                3'd1: v = 8'h50;
                3'd2: v = 8'h4E;
                3'd3: v = 8'h47;
                3'd4: v = 8'h0D;
                3'd5: v = 8'h0A;
                3'd6: v = 8'h1A;
                default: v = 8'h0A;
            endcase
            return v;
        end
    endfunction

    function automatic logic [7:0] exif_hdr_byte(input logic [2:0] idx);
        logic [7:0] v;
        begin
            unique case (idx)
                3'd0: v = 8'h45;
                3'd1: v = 8'h78;
                3'd2: v = 8'h69;
                3'd3: v = 8'h66;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

endpackage

>>> design/exif_front.sv
// ----------------------------------------------------------------------------
// exif_front: byte parser
// Walks the container and TIFF block one byte per cycle while take is high; on the byte that
// ends a file's scan it forms one result item.
// ----------------------------------------------------------------------------
module exif_front
    import exif_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output logic          res_valid,
    output result_t       res
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    phase_t            phase_reg, phase_next;
    logic [1:0]        cont_reg, cont_next;
    logic [3:0]        k_reg, k_next;
    logic [31:0]       rem_reg, rem_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic              le_reg, le_next;
    logic [31:0]       ifd_reg, ifd_next;
    logic [15:0]       ent_reg, ent_next;
    logic [31:0]       asm_reg, asm_next;
    logic [15:0]       tag_reg, tag_next;
    logic [15:0]       typ_reg, typ_next;
    logic              nz_reg, nz_next;
    logic [3:0]        ori_reg, ori_next;
    logic              sent_reg, sent_next;
    logic [7:0]        mark_reg, mark_next;
    logic              hok_reg, hok_next;

    logic              stop;
    logic [31:0]       gath;
    logic [1:0]        gk;
    logic [32:0]       size_w;
    logic [32:0]       off2;
    logic [15:0]       len16;
    logic              trunc;
    logic [3:0]        o_out;

    // little-endian places byte at its lane; big-endian shifts in
    always_comb
    begin
        unique case (phase_reg)
            PH_TENTRY: gk = (k_reg >= 4'd8) ? 2'(k_reg - 4'd8) : {1'b0, k_reg[0]};
            default:   gk = k_reg[1:0];
        endcase
        if (le_reg)
            gath = ((gk == 2'd0) ? 32'd0 : asm_reg) | (32'(data_byte) << (8 * gk));
        else
            gath = (((gk == 2'd0) ? 32'd0 : asm_reg) << 8) | 32'(data_byte);
    end

    assign size_w = 33'(pos_reg) + 33'(rem_reg);
    assign off2   = 33'(gath) + 33'd2;
    assign len16  = {asm_reg[7:0], data_byte};

    always_comb
    begin
        phase_next = phase_reg; cont_next = cont_reg; k_next = k_reg;
        rem_next = rem_reg; pos_next = pos_reg; le_next = le_reg;
        ifd_next = ifd_reg; ent_next = ent_reg; asm_next = asm_reg;
        tag_next = tag_reg; typ_next = typ_reg; nz_next = nz_reg;
        ori_next = ori_reg; sent_next = sent_reg; mark_next = mark_reg;
        hok_next = hok_reg;
        stop = 1'b0;
        unique case (phase_reg)
            PH_FIRST:
            begin
                asm_next = 32'(data_byte); phase_next = PH_SECOND;
            end
            PH_SECOND:
            begin
                if (asm_reg == 32'hFF && data_byte == MARK_SOI)
                begin
                    cont_next = CONT_JPEG; phase_next = PH_JSCAN;
                end
                else if (asm_reg == 32'(PNG_FIRST) && data_byte == 8'h50)
                begin
                    cont_next = CONT_PNG; phase_next = PH_PNGSIG; k_next = 4'd2;
                end
                else
                    stop = 1'b1;
            end
            PH_PNGSIG:
            begin
                if (k_reg >= 4'd8 || data_byte != png_sig_byte(k_reg[2:0]))
                    stop = 1'b1;
                else if (k_reg == 4'd7)
                begin
                    phase_next = PH_PLEN; k_next = '0;
                end
                else
                    k_next = k_reg + 4'd1;
            end
            PH_JSCAN:
            begin
                if (data_byte == 8'hFF)
                    phase_next = PH_JMARK;
            end
            PH_JMARK:
            begin
                priority if (data_byte == 8'hFF)
                    phase_next = PH_JMARK;
                else if (data_byte == MARK_SOI || data_byte == MARK_TEM
                         || (data_byte >= 8'hD0 && data_byte <= 8'hD7))
                    phase_next = PH_JSCAN;
                else if (data_byte == MARK_SOS || data_byte == MARK_EOI)
                    stop = 1'b1;
                else
                begin
                    mark_next = data_byte; phase_next = PH_JLEN; k_next = '0;
                end
            end
            PH_JLEN:
            begin
                if (k_reg == 4'd0)
                begin
                    asm_next = 32'(data_byte); k_next = 4'd1;
                end
                else
                begin
                    k_next = '0;
                    if (len16 < 16'd2)
                        stop = 1'b1;
                    else
                    begin
                        rem_next = 32'(len16 - 16'd2);
                        if (mark_reg == MARK_APP1 && len16 >= 16'd8)
                            phase_next = PH_JEXIF;
                        else if (len16 == 16'd2)
                            phase_next = PH_JSCAN;
                        else
                            phase_next = PH_JSKIP;
                    end
                end
            end
            PH_JSKIP:
            begin
                if (rem_reg != '0) rem_next = rem_reg - 32'd1;
                if (rem_reg <= 32'd1) phase_next = PH_JSCAN;
            end
            PH_JEXIF:
            begin
                if (rem_reg != '0) rem_next = rem_reg - 32'd1;
                if (k_reg >= 4'd6 || data_byte != exif_hdr_byte(k_reg[2:0]))
                begin
                    k_next = '0;
                    phase_next = (rem_reg <= 32'd1) ? PH_JSCAN : PH_JSKIP;
                end
                else if (k_reg == 4'd5)
                begin
                    pos_next = '0; k_next = '0; le_next = 1'b0;
                    if (rem_next == '0) stop = 1'b1;
                    else phase_next = (rem_next < 32'd8) ? PH_TTAIL : PH_TBO;
                end
                else
                    k_next = k_reg + 4'd1;
            end
            PH_PLEN, PH_PTYPE:
            begin
                asm_next = ((k_reg == 4'd0) ? 32'd0 : (asm_reg << 8)) | 32'(data_byte);
                if (k_reg < 4'd3)
                    k_next = k_reg + 4'd1;
                else
                begin
                    k_next = '0;
                    if (phase_reg == PH_PLEN)
                    begin
                        rem_next = asm_next; phase_next = PH_PTYPE;
                    end
                    else if (asm_next == CHUNK_EXIF)
                    begin
                        pos_next = '0; le_next = 1'b0;
                        if (rem_reg == '0) stop = 1'b1;
                        else phase_next = (rem_reg < 32'd8) ? PH_TTAIL : PH_TBO;
                    end
                    else if (asm_next == CHUNK_IDAT || asm_next == CHUNK_IEND)
                        stop = 1'b1;
                    else
                        phase_next = (rem_reg == '0) ? PH_PCRC : PH_PSKIP;
                end
            end
            PH_PSKIP:
            begin
                if (rem_reg != '0) rem_next = rem_reg - 32'd1;
                if (rem_reg <= 32'd1)
                begin
                    phase_next = PH_PCRC; k_next = '0;
                end
            end
            PH_PCRC:
            begin
                if (k_reg >= 4'd3)
                begin
                    phase_next = PH_PLEN; k_next = '0;
                end
                else
                    k_next = k_reg + 4'd1;
            end
            default:
            begin
                // TIFF block phases
                unique case (phase_reg)
                    PH_TBO:
                    begin
                        if (k_reg == 4'd0)
                        begin
                            asm_next = 32'(data_byte); k_next = 4'd1;
                        end
                        else if (asm_reg == 32'h49 && data_byte == 8'h49)
                        begin
                            le_next = 1'b1; phase_next = PH_TMAGIC; k_next = '0;
                        end
                        else if (asm_reg == 32'h4D && data_byte == 8'h4D)
                        begin
                            le_next = 1'b0; phase_next = PH_TMAGIC; k_next = '0;
                        end
                        else
                            phase_next = PH_TTAIL;
                    end
                    PH_TMAGIC:
                    begin
                        asm_next = gath;
                        if (k_reg == 4'd0)
                            k_next = 4'd1;
                        else
                        begin
                            k_next = '0;
                            if (gath[15:0] == 16'd42)
                            begin
                                hok_next = 1'b1; phase_next = PH_TOFF;
                            end
                            else
                                phase_next = PH_TTAIL;
                        end
                    end
                    PH_TOFF:
                    begin
                        asm_next = gath;
                        if (k_reg < 4'd3)
                            k_next = k_reg + 4'd1;
                        else
                        begin
                            k_next = '0;
                            ifd_next = gath;
                            if (gath < 32'd8 || off2 > size_w || 33'(gath) > 33'(POS_MAX))
                                phase_next = PH_TTAIL;
                            else if (gath == 32'd8)
                                phase_next = PH_TCOUNT;
                            else
                                phase_next = PH_TSEEK;
                        end
                    end
                    PH_TSEEK:
                    begin
                        if (33'(pos_reg) + 33'd1 == 33'(ifd_reg))
                        begin
                            phase_next = PH_TCOUNT; k_next = '0;
                        end
                    end
                    PH_TCOUNT:
                    begin
                        asm_next = gath;
                        if (k_reg == 4'd0)
                            k_next = 4'd1;
                        else
                        begin
                            k_next = '0;
                            ent_next = gath[15:0];
                            phase_next = (gath[15:0] == '0) ? PH_TTAIL : PH_TENTRY;
                        end
                    end
                    PH_TENTRY:
                    begin
                        if (k_reg == 4'd0 && rem_reg < 32'd12)
                            phase_next = PH_TTAIL;
                        else
                        begin
                            if (k_reg < 4'd4 || (k_reg >= 4'd8 && k_reg < 4'd10))
                                asm_next = gath;
                            if (k_reg == 4'd1) tag_next = gath[15:0];
                            if (k_reg == 4'd3) typ_next = gath[15:0];
                            if (k_reg >= 4'd4 && k_reg < 4'd8)
                                nz_next = ((k_reg == 4'd4) ? 1'b0 : nz_reg)
                                          || (data_byte != 8'd0);
                            if (k_reg == 4'd9 && tag_reg == TAG_ORIENT && typ_reg == 16'd3
                                && nz_reg && gath[15:0] >= 16'd1 && gath[15:0] <= 16'd8)
                                ori_next = gath[3:0];
                            if (k_reg >= 4'd11)
                            begin
                                k_next = '0;
                                ent_next = ent_reg - 16'd1;
                                if (ent_reg == 16'd1) phase_next = PH_TTAIL;
                            end
                            else
                                k_next = k_reg + 4'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (pos_reg < POS_MAX) pos_next = pos_reg + 1'b1;
                rem_next = (rem_reg != '0) ? rem_reg - 32'd1 : rem_reg;
                if (rem_reg <= 32'd1) stop = 1'b1;
            end
        endcase

        // the PNG eXIf start-of-TIFF path keeps the chunk length as the TIFF size
        if (phase_reg == PH_PTYPE && k_reg == 4'd3 && asm_next == CHUNK_EXIF)
            rem_next = rem_reg;

        if (sent_reg)
        begin
            phase_next = phase_reg; cont_next = cont_reg; k_next = k_reg;
            rem_next = rem_reg; pos_next = pos_reg; le_next = le_reg;
            ifd_next = ifd_reg; ent_next = ent_reg; asm_next = asm_reg;
            tag_next = tag_reg; typ_next = typ_reg; nz_next = nz_reg;
            ori_next = ori_reg; mark_next = mark_reg; hok_next = hok_reg;
            stop = 1'b0;
        end
        else if (stop)
            sent_next = 1'b1;
    end

    // result item from the state after this byte, with the truncated-eXIf case
    assign trunc = !stop && !sent_reg && cont_next == CONT_PNG && phase_next >= PH_TBO;
    assign o_out = trunc ? 4'd0 : ori_next;
    assign res_valid = take && !sent_reg && (stop || last_byte);
    assign res.orientation = o_out;
    assign res.container = cont_next;
    assign res.exif_present = !trunc && hok_next;
    assign res.swaps_axes = o_out >= 4'd5 && o_out <= 4'd8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST; cont_reg <= '0; k_reg <= '0; rem_reg <= '0;
            pos_reg <= '0; le_reg <= 1'b0; ifd_reg <= '0; ent_reg <= '0;
            asm_reg <= '0; tag_reg <= '0; typ_reg <= '0; nz_reg <= 1'b0;
            ori_reg <= '0; sent_reg <= 1'b0; mark_reg <= '0; hok_reg <= 1'b0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                phase_reg <= PH_FIRST; cont_reg <= '0; k_reg <= '0; rem_reg <= '0;
                pos_reg <= '0; le_reg <= 1'b0; ifd_reg <= '0; ent_reg <= '0;
                asm_reg <= '0; tag_reg <= '0; typ_reg <= '0; nz_reg <= 1'b0;
                ori_reg <= '0; sent_reg <= 1'b0; mark_reg <= '0; hok_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next; cont_reg <= cont_next; k_reg <= k_next;
                rem_reg <= rem_next; pos_reg <= pos_next; le_reg <= le_next;
                ifd_reg <= ifd_next; ent_reg <= ent_next; asm_reg <= asm_next;
                tag_reg <= tag_next; typ_reg <= typ_next; nz_reg <= nz_next;
                ori_reg <= ori_next; sent_reg <= sent_next; mark_reg <= mark_next;
                hok_reg <= hok_next;
            end
        end
    end

    a_one_per_file: assert property (@(posedge clk) disable iff (!rst_n)
        (take && sent_reg) |-> !res_valid)
        else $error("second result in one file");
    a_swap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.swaps_axes == (res.orientation >= 4'd5)))
        else $error("swap flag mismatch");
    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_byte) |=> (phase_reg == PH_FIRST && !sent_reg))
        else $error("no restart after last byte");

endmodule

>>> design/exif_queue.sv
// ----------------------------------------------------------------------------
// exif_queue: result queue
// Short FIFO of result items between the parser and the output port.
// ----------------------------------------------------------------------------
module exif_queue
    import exif_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    not_empty,
    output logic    full,
    output result_t head
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    result_t       mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign not_empty = cnt_reg != '0;
    assign full = cnt_reg == (AW+1)'(QUEUE_DEPTH);
    assign head = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("count slip");

endmodule

>>> design/exif_orientation_stream_parser_core.sv
// ----------------------------------------------------------------------------
// exif_orientation_stream_parser_core: EXIF orientation finder
// Scans JPEG or PNG files byte by byte and gives one result item per file.
// ----------------------------------------------------------------------------
//  channel | direction | handshake      | payload
//  in      | input     | in_valid/stall | data_byte, last_byte
//  out     | output    | out_valid/stall| orientation, container, exif_present,
//          |           |                | swaps_axes
//
// One byte is taken every cycle unless the queue is full; the parser updates
// its counters on each byte taken. A result item is registered in a four-entry
// queue and leaves from its head. The input stalls only while that queue is
// full. Reset clears the parser to await the first byte of a new file.
module exif_orientation_stream_parser_core
    import exif_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] orientation,
    output logic [1:0] container,
    output logic       exif_present,
    output logic       swaps_axes
);

    logic    take, res_valid, q_full, pop;
    result_t res, head;

    // hold input while the queue is full
    assign in_stall = q_full;
    assign take = in_valid && !q_full;
    assign pop = out_valid && !out_stall;

    exif_front #(.POSITION_BITS(POSITION_BITS)) u_front
    (
        .clk(clk), .rst_n(rst_n), .take(take), .data_byte(data_byte),
        .last_byte(last_byte), .res_valid(res_valid), .res(res)
    );

    exif_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .push(res_valid), .push_data(res), .pop(pop),
        .not_empty(out_valid), .full(q_full), .head(head)
    );

    assign orientation = head.orientation;
    assign container = head.container;
    assign exif_present = head.exif_present;
    assign swaps_axes = head.swaps_axes;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("stall with empty queue");
    a_orient_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> orientation <= 4'd8)
        else $error("orientation out of range");
    a_no_orient_png0: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && container == CONT_NONE) |-> (orientation == 4'd0 && !exif_present))
        else $error("result without container");

endmodule
